FILE: src/mst_pkg.sv
package mst_pkg;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_FINAL  = 2'd1,
    MODE_LOOKUP = 2'd2
  } mst_mode_e;

  typedef enum logic [2:0] {
    ST_ADDED = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL  = 3'd2,
    ST_HIT   = 3'd3,
    ST_MISS  = 3'd4,
    ST_OTHER = 3'd5
  } mst_status_e;

  typedef enum logic {
    RD_I   = 1'b0,
    RD_JM1 = 1'b1
  } mst_rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE    = 3'd0,
    WR_NEW     = 3'd1,
    WR_J_RDATA = 3'd2,
    WR_J_HOLD  = 3'd3,
    WR_K_RDATA = 3'd4
  } mst_wr_sel_e;

  typedef enum logic [1:0] {
    I_HOLD = 2'd0,
    I_ZERO = 2'd1,
    I_ONE  = 2'd2,
    I_INC  = 2'd3
  } mst_i_op_e;

  typedef struct packed {
    logic [31:0] flags;
    logic [63:0] size;
    logic [63:0] base;
  } mst_entry_t;

  typedef struct packed {
    logic        in_take;
    logic        res_set;
    mst_status_e res_status;
    logic        res_hit;
    mst_wr_sel_e wr_sel;
    mst_rd_sel_e rd_sel;
    mst_i_op_e   i_op;
    logic        j_load;
    logic        j_dec;
    logic        k_zero;
    logic        hold_load;
    logic        finish_fin;
    logic        out_load;
  } mst_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       size_zero;
    logic       full;
    logic       finalized;
    logic       i_end;
    logic       j_zero;
    logic       goes_first;
    logic       keep;
    logic       hit;
    logic       out_free;
  } mst_stat_t;

endpackage

FILE: src/memory_segment_table.sv
// add: decode, then the add state sets the result; the done state waits for a free output
// register and loads it there; unused mode and lookup before finalize go from decode to done
// lookup over n kept entries: a load state and a check state per entry on the ram read port,
// stopping at the first hit; a miss scans all n kept entries
// finalize over n entries: insertion sort then compaction;
// one transaction in work at a time, the next taken while a result waits; async reset empties
module memory_segment_table #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [223:0] s_axis_tdata,   // seg_base, seg_size, seg_flags_in, address
  input  logic [1:0]   s_axis_tuser,   // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [175:0] m_axis_tdata,   // kept_count, hit_index, hit_flags, hit_offset,
                                       // hit_remaining, zero fill
  output logic [2:0]   m_axis_tuser    // status
);
  import mst_pkg::*;

  mst_cmd_t    cmd;
  mst_stat_t   stat;
  logic [4:0]  out_count;
  logic [3:0]  out_index;
  logic [31:0] out_flags;
  logic [63:0] out_offset, out_remaining;

  mst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  mst_dp #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_mode_i      (s_axis_tuser),
    .in_base_i      (s_axis_tdata[63:0]),
    .in_size_i      (s_axis_tdata[127:64]),
    .in_flags_i     (s_axis_tdata[159:128]),
    .in_addr_i      (s_axis_tdata[223:160]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_status_o   (m_axis_tuser),
    .out_count_o    (out_count),
    .out_index_o    (out_index),
    .out_flags_o    (out_flags),
    .out_offset_o   (out_offset),
    .out_remaining_o(out_remaining)
  );

  assign m_axis_tdata = {7'b0, out_remaining, out_offset, out_flags, out_index, out_count};

endmodule

FILE: src/mst_ram.sv
module mst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/mst_ctrl.sv
module mst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mst_pkg::mst_stat_t stat_i,
  output mst_pkg::mst_cmd_t  cmd_o
);
  import mst_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_DECODE    = 12'b0000_0000_0010,
    S_ADD       = 12'b0000_0000_0100,
    S_SORT_LOAD = 12'b0000_0000_1000,
    S_SORT_HOLD = 12'b0000_0001_0000,
    S_SORT_NEXT = 12'b0000_0010_0000,
    S_SORT_CMP  = 12'b0000_0100_0000,
    S_COMP_LOAD = 12'b0000_1000_0000,
    S_COMP_CHK  = 12'b0001_0000_0000,
    S_LOOK_LOAD = 12'b0010_0000_0000,
    S_LOOK_CHK  = 12'b0100_0000_0000,
    S_DONE      = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.res_status = ST_OTHER;
    cmd_o.wr_sel = WR_NONE;
    cmd_o.rd_sel = RD_I;
    cmd_o.i_op = I_HOLD;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_take = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.mode)
          MODE_ADD: begin
            state_d = S_ADD;
          end
          MODE_FINAL: begin
            cmd_o.i_op = I_ONE;
            cmd_o.res_set = 1'b1;
            cmd_o.res_status = ST_OTHER;
            state_d = S_SORT_LOAD;
          end
          MODE_LOOKUP: begin
            cmd_o.res_set = 1'b1;
            if (stat_i.finalized) begin
              cmd_o.i_op = I_ZERO;
              cmd_o.res_status = ST_MISS;
              state_d = S_LOOK_LOAD;
            end else begin
              cmd_o.res_status = ST_OTHER;
              state_d = S_DONE;
            end
          end
          default: begin
            cmd_o.res_set = 1'b1;
            cmd_o.res_status = ST_OTHER;
            state_d = S_DONE;
          end
        endcase
      end
      S_ADD: begin
        cmd_o.res_set = 1'b1;
        if (stat_i.size_zero) begin
          cmd_o.res_status = ST_EMPTY;
        end else if (stat_i.full) begin
          cmd_o.res_status = ST_FULL;
        end else begin
          cmd_o.res_status = ST_ADDED;
          cmd_o.wr_sel = WR_NEW;
        end
        state_d = S_DONE;
      end
      S_SORT_LOAD: begin
        if (stat_i.i_end) begin
          cmd_o.i_op = I_ZERO;
          cmd_o.k_zero = 1'b1;
          state_d = S_COMP_LOAD;
        end else begin
          cmd_o.rd_sel = RD_I;
          cmd_o.j_load = 1'b1;
          state_d = S_SORT_HOLD;
        end
      end
      S_SORT_HOLD: begin
        cmd_o.hold_load = 1'b1;
        state_d = S_SORT_NEXT;
      end
      S_SORT_NEXT: begin
        if (stat_i.j_zero) begin
          cmd_o.wr_sel = WR_J_HOLD;
          cmd_o.i_op = I_INC;
          state_d = S_SORT_LOAD;
        end else begin
          cmd_o.rd_sel = RD_JM1;
          state_d = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        if (stat_i.goes_first) begin
          cmd_o.wr_sel = WR_J_RDATA;
          cmd_o.j_dec = 1'b1;
          state_d = S_SORT_NEXT;
        end else begin
          cmd_o.wr_sel = WR_J_HOLD;
          cmd_o.i_op = I_INC;
          state_d = S_SORT_LOAD;
        end
      end
      S_COMP_LOAD: begin
        if (stat_i.i_end) begin
          cmd_o.finish_fin = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_sel = RD_I;
          state_d = S_COMP_CHK;
        end
      end
      S_COMP_CHK: begin
        if (stat_i.keep) begin
          cmd_o.wr_sel = WR_K_RDATA;
        end
        cmd_o.i_op = I_INC;
        state_d = S_COMP_LOAD;
      end
      S_LOOK_LOAD: begin
        if (stat_i.i_end) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_sel = RD_I;
          state_d = S_LOOK_CHK;
        end
      end
      S_LOOK_CHK: begin
        if (stat_i.hit) begin
          cmd_o.res_hit = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.i_op = I_INC;
          state_d = S_LOOK_LOAD;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/mst_dp.sv
module mst_dp #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mst_pkg::mst_cmd_t  cmd_i,
  output mst_pkg::mst_stat_t stat_o,
  input  logic [1:0]         in_mode_i,
  input  logic [63:0]        in_base_i,
  input  logic [63:0]        in_size_i,
  input  logic [31:0]        in_flags_i,
  input  logic [63:0]        in_addr_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [2:0]         out_status_o,
  output logic [4:0]         out_count_o,
  output logic [3:0]         out_index_o,
  output logic [31:0]        out_flags_o,
  output logic [63:0]        out_offset_o,
  output logic [63:0]        out_remaining_o
);
  import mst_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = $bits(mst_entry_t);

  logic [1:0]  mode_q;
  logic [63:0] base_q, size_q, addr_q;
  logic [31:0] flags_q;

  logic [CW-1:0] count_q, i_q, j_q, k_q;
  logic [CW-1:0] jm1;
  logic          fin_q;
  mst_entry_t    hold_q;
  logic [64:0]   last_end_q;

  logic [2:0]  res_status_q;
  logic [3:0]  res_index_q;
  logic [31:0] res_flags_q;
  logic [63:0] res_offset_q, res_remaining_q;

  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic [4:0]  out_count_q;
  logic [3:0]  out_index_q;
  logic [31:0] out_flags_q;
  logic [63:0] out_offset_q, out_remaining_q;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  mst_entry_t    wdata, rdata;
  logic [EW-1:0] rdata_raw;
  logic [63:0]   offset;
  logic [CW+4:0] count_ext;
  logic [CW+3:0] i_ext;

  assign jm1 = j_q - CW'(1);
  assign offset = addr_q - rdata.base;
  assign count_ext = {5'b0, count_q};
  assign i_ext = {4'b0, i_q};
  assign rdata = mst_entry_t'(rdata_raw);

  always_comb begin
    we = 1'b1;
    waddr = j_q[IW-1:0];
    wdata = rdata;
    case (cmd_i.wr_sel)
      WR_NEW: begin
        waddr = count_q[IW-1:0];
        wdata = '{flags: flags_q, size: size_q, base: base_q};
      end
      WR_J_RDATA: begin
        waddr = j_q[IW-1:0];
        wdata = rdata;
      end
      WR_J_HOLD: begin
        waddr = j_q[IW-1:0];
        wdata = hold_q;
      end
      WR_K_RDATA: begin
        waddr = k_q[IW-1:0];
        wdata = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign raddr = (cmd_i.rd_sel == RD_JM1) ? jm1[IW-1:0] : i_q[IW-1:0];

  mst_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_SEGMENTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(EW'(wdata)),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  always_comb begin
    stat_o.mode = mode_q;
    stat_o.size_zero = (size_q == 64'd0);
    stat_o.full = (count_q == CW'(MAX_SEGMENTS));
    stat_o.finalized = fin_q;
    stat_o.i_end = (i_q >= count_q);
    stat_o.j_zero = (j_q == '0);
    stat_o.goes_first = (hold_q.base < rdata.base) ||
                        ((hold_q.base == rdata.base) && (hold_q.size > rdata.size));
    stat_o.keep = (k_q == '0) || ({1'b0, rdata.base} >= last_end_q);
    stat_o.hit = (addr_q >= rdata.base) && (offset < rdata.size);
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      fin_q <= 1'b0;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_sel == WR_NEW) begin
        count_q <= count_q + CW'(1);
        fin_q <= 1'b0;
      end
      if (cmd_i.finish_fin) begin
        count_q <= k_q;
        fin_q <= 1'b1;
      end
      case (cmd_i.i_op)
        I_ZERO:  i_q <= '0;
        I_ONE:   i_q <= CW'(1);
        I_INC:   i_q <= i_q + CW'(1);
        default: i_q <= i_q;
      endcase
      if (cmd_i.j_load) begin
        j_q <= i_q;
      end else if (cmd_i.j_dec) begin
        j_q <= jm1;
      end
      if (cmd_i.k_zero) begin
        k_q <= '0;
      end else if (cmd_i.wr_sel == WR_K_RDATA) begin
        k_q <= k_q + CW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      mode_q <= in_mode_i;
      base_q <= in_base_i;
      size_q <= in_size_i;
      flags_q <= in_flags_i;
      addr_q <= in_addr_i;
    end
    if (cmd_i.hold_load) begin
      hold_q <= rdata;
    end
    if (cmd_i.wr_sel == WR_K_RDATA) begin
      last_end_q <= {1'b0, rdata.base} + {1'b0, rdata.size};
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_index_q <= '0;
      res_flags_q <= '0;
      res_offset_q <= '0;
      res_remaining_q <= '0;
    end else if (cmd_i.res_hit) begin
      res_status_q <= ST_HIT;
      res_index_q <= i_ext[3:0];
      res_flags_q <= rdata.flags;
      res_offset_q <= offset;
      res_remaining_q <= rdata.size - offset;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_count_q <= count_ext[4:0];
      out_index_q <= res_index_q;
      out_flags_q <= res_flags_q;
      out_offset_q <= res_offset_q;
      out_remaining_q <= res_remaining_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_count_o = out_count_q;
  assign out_index_o = out_index_q;
  assign out_flags_o = out_flags_q;
  assign out_offset_o = out_offset_q;
  assign out_remaining_o = out_remaining_q;

endmodule

FILE: bench/tb_memory_segment_table.sv
module tb_memory_segment_table;
  import mst_pkg::*;

  localparam int NUM_SEGS = 16;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 400;
  localparam logic [63:0] TOP_BASE = 64'hFFFF_FFFF_FFFF_FFF0;

  typedef struct packed {
    mst_status_e status;
    logic [4:0]  kept;
    logic [3:0]  hit_idx;
    logic [31:0] hit_flags;
    logic [63:0] hit_offset;
    logic [63:0] hit_remaining;
  } seg_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [175:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  // segment table as the block should hold it
  logic [63:0] tbl_base [NUM_SEGS];
  logic [63:0] tbl_size [NUM_SEGS];
  logic [31:0] tbl_flags [NUM_SEGS];
  int          tbl_count = 0;
  bit          tbl_ready = 1'b0;

  seg_result_t result_q[$];
  int          error_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          round_no = 0;
  bit          hold_pending = 1'b0;
  logic [63:0] region_base = '0;

  memory_segment_table #(
    .MAX_SEGMENTS(NUM_SEGS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic seg_result_t predict_table_op(logic [1:0] mode, logic [63:0] base,
                                                   logic [63:0] size, logic [31:0] flags,
                                                   logic [63:0] addr);
    seg_result_t res;
    int          i;
    int          j;
    int          k;
    logic [63:0] b;
    logic [63:0] s;
    logic [31:0] f;
    logic [64:0] seg_end;
    bit          keep;
    bit          found;
    res = '0;
    res.status = ST_OTHER;
    case (mode)
      MODE_ADD: begin
        if (size == 64'd0) begin
          res.status = ST_EMPTY;
        end else if (tbl_count >= NUM_SEGS) begin
          res.status = ST_FULL;
        end else begin
          tbl_base[tbl_count] = base;
          tbl_size[tbl_count] = size;
          tbl_flags[tbl_count] = flags;
          tbl_count++;
          tbl_ready = 1'b0;
          res.status = ST_ADDED;
        end
      end
      MODE_FINAL: begin
        // stable insertion sort: base ascending, size descending
        for (i = 1; i < tbl_count; i++) begin
          b = tbl_base[i];
          s = tbl_size[i];
          f = tbl_flags[i];
          j = i;
          while (j > 0 && (b < tbl_base[j-1] || (b == tbl_base[j-1] && s > tbl_size[j-1])))
          begin
            tbl_base[j] = tbl_base[j-1];
            tbl_size[j] = tbl_size[j-1];
            tbl_flags[j] = tbl_flags[j-1];
            j--;
          end
          tbl_base[j] = b;
          tbl_size[j] = s;
          tbl_flags[j] = f;
        end
        // keep a segment only past the carried end of the last kept one
        k = 0;
        for (i = 0; i < tbl_count; i++) begin
          keep = 1'b1;
          if (k > 0) begin
            seg_end = {1'b0, tbl_base[k-1]} + {1'b0, tbl_size[k-1]};
            if (seg_end[64] || tbl_base[i] < seg_end[63:0]) keep = 1'b0;
          end
          if (keep) begin
            tbl_base[k] = tbl_base[i];
            tbl_size[k] = tbl_size[i];
            tbl_flags[k] = tbl_flags[i];
            k++;
          end
        end
        tbl_count = k;
        tbl_ready = 1'b1;
      end
      MODE_LOOKUP: begin
        if (tbl_ready) begin
          res.status = ST_MISS;
          found = 1'b0;
          for (i = 0; i < tbl_count; i++) begin
            if (!found && addr >= tbl_base[i] && addr - tbl_base[i] < tbl_size[i]) begin
              found = 1'b1;
              res.status = ST_HIT;
              res.hit_idx = 4'(i);
              res.hit_flags = tbl_flags[i];
              res.hit_offset = addr - tbl_base[i];
              res.hit_remaining = tbl_size[i] - res.hit_offset;
            end
          end
        end
      end
      default: ;
    endcase
    res.kept = 5'(tbl_count);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < 100) begin
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    end
    error_count++;
  endtask

  task automatic send_item(logic [1:0] mode, logic [63:0] base, logic [63:0] size,
                           logic [31:0] flags, logic [63:0] addr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {addr, flags, size, base};
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    result_q.insert(result_q.size(), predict_table_op(mode, base, size, flags, addr));
    items_sent++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 9))
      0, 1, 2: send_item(MODE_UNUSED, rnd64(), rnd64(), $urandom, rnd64());
      3, 4:    send_item(MODE_ADD, rnd64(), 64'd0, $urandom, rnd64());
      5:       send_item(MODE_ADD, rnd64(), rnd64(), $urandom, rnd64());
      default: send_item(MODE_LOOKUP, rnd64(), rnd64(), $urandom, rnd64());
    endcase
  endtask

  // mostly addresses inside, at the edges of, or just past a kept segment
  function automatic logic [63:0] pick_lookup_addr();
    int unsigned idx;
    logic [63:0] b;
    logic [63:0] s;
    logic [63:0] off;
    if (tbl_count == 0 || $urandom_range(0, 9) < 3) begin
      if ($urandom_range(0, 1) == 0) return rnd64();
      return region_base + $urandom_range(0, 1 << 17);
    end
    idx = $urandom_range(0, tbl_count - 1);
    b = tbl_base[idx];
    s = tbl_size[idx];
    case ($urandom_range(0, 5))
      0: off = '0;
      1: off = s - 64'd1;
      2: off = s;
      default: begin
        if (s <= 64'hFFFF_FFFF) off = 64'($urandom_range(0, s[31:0] - 1));
        else off = rnd64() % s;
      end
    endcase
    return b + off;
  endfunction

  // sweeper at base zero grows each round, so older regions and low junk drop out
  task automatic random_round();
    int          n_adds;
    int          n_looks;
    int          i;
    logic [63:0] sweep;
    logic [63:0] size;
    if (round_no < 63) round_no++;
    sweep = (64'(round_no) << 58) | (rnd64() & 64'hFF_FFFF_FFFF);
    region_base = sweep;
    send_item(MODE_ADD, '0, sweep, $urandom, rnd64());
    n_adds = $urandom_range(3, 20);
    for (i = 0; i < n_adds; i++) begin
      if ($urandom_range(0, 5) == 0) send_noise();
      if ($urandom_range(0, 7) == 0) begin
        send_item(MODE_LOOKUP, rnd64(), rnd64(), $urandom, pick_lookup_addr());
      end
      case ($urandom_range(0, 7))
        0: size = 64'($urandom) + 64'd1;
        1: size = 64'($urandom_range(1, 16));
        default: size = 64'($urandom_range(16'h2000, 16'h4000));
      endcase
      send_item(MODE_ADD, region_base + $urandom_range(0, 1 << 16), size, $urandom, rnd64());
    end
    send_item(MODE_FINAL, rnd64(), rnd64(), $urandom, rnd64());
    if ($urandom_range(0, 3) == 0) send_item(MODE_FINAL, rnd64(), rnd64(), $urandom, rnd64());
    n_looks = $urandom_range(8, 25);
    for (i = 0; i < n_looks; i++) begin
      if ($urandom_range(0, 5) == 0) send_noise();
      send_item(MODE_LOOKUP, rnd64(), rnd64(), $urandom, pick_lookup_addr());
    end
  endtask

  task automatic test_directed();
    send_item(MODE_LOOKUP, '0, '0, '0, '0);
    send_item(MODE_UNUSED, '1, '1, '1, '1);
    send_item(MODE_ADD, '1, '0, '1, '0);
    send_item(MODE_FINAL, '0, '0, '0, '0);
    send_item(MODE_LOOKUP, '0, '0, '0, '1);
    send_item(MODE_ADD, 64'h0, 64'h1, 32'h0, '0);
    send_item(MODE_ADD, 64'h10, 64'h10, 32'hAAAA_5555, '0);
    send_item(MODE_ADD, 64'h10, 64'h10, 32'h5555_AAAA, '0);
    send_item(MODE_ADD, 64'h18, 64'h4, 32'h1234_5678, '0);
    send_item(MODE_ADD, 64'h20, 64'h20, 32'hFFFF_FFFF, '0);
    send_item(MODE_ADD, TOP_BASE, 64'h20, 32'h8000_0001, '0);
    send_item(MODE_ADD, '1, 64'h1, 32'h7FFF_FFFE, '0);
    send_item(MODE_LOOKUP, '0, '0, '0, 64'h10);
    send_item(MODE_FINAL, '0, '0, '0, '0);
    send_item(MODE_FINAL, '0, '0, '0, '0);
    send_item(MODE_LOOKUP, '0, '0, '0, 64'h0);
    send_item(MODE_LOOKUP, '0, '0, '0, 64'h10);
    send_item(MODE_LOOKUP, '0, '0, '0, 64'h3F);
    send_item(MODE_LOOKUP, '0, '0, '0, 64'h40);
    send_item(MODE_LOOKUP, '0, '0, '0, '1);
    // add after finalize of a segment whose end carries out
    send_item(MODE_ADD, 64'h40, '1, '1, '0);
    send_item(MODE_LOOKUP, '0, '0, '0, '1);
    send_item(MODE_FINAL, '0, '0, '0, '0);
    send_item(MODE_LOOKUP, '0, '0, '0, '1);
  endtask

  task automatic test_random(int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) random_round();
  endtask

  task automatic test_backpressure();
    int i;
    wait_for_results();
    hold_pending = 1'b1;
    for (i = 0; i < 30; i++) begin
      send_item(MODE_LOOKUP, rnd64(), rnd64(), $urandom, pick_lookup_addr());
    end
    wait_for_results();
  endtask

  initial begin : ready_pattern
    int hold_left;
    int window_left;
    int stall_pct;
    hold_left = 0;
    window_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (window_left == 0) begin
          window_left = $urandom_range(16, 128);
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 20;
            3: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        window_left--;
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    seg_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        report_mismatch("result with nothing expected", 64'(m_axis_tuser), '0);
      end else begin
        want = result_q.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
        if (m_axis_tdata[4:0] !== want.kept)
          report_mismatch("kept_count", 64'(m_axis_tdata[4:0]), 64'(want.kept));
        if (m_axis_tdata[8:5] !== want.hit_idx)
          report_mismatch("hit_index", 64'(m_axis_tdata[8:5]), 64'(want.hit_idx));
        if (m_axis_tdata[40:9] !== want.hit_flags)
          report_mismatch("hit_flags", 64'(m_axis_tdata[40:9]), 64'(want.hit_flags));
        if (m_axis_tdata[104:41] !== want.hit_offset)
          report_mismatch("hit_offset", m_axis_tdata[104:41], want.hit_offset);
        if (m_axis_tdata[168:105] !== want.hit_remaining)
          report_mismatch("hit_remaining", m_axis_tdata[168:105], want.hit_remaining);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(600);
    test_backpressure();
    test_random(600);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (result_q.size() != 0) begin
      report_mismatch("results never arrived", 64'(result_q.size()), '0);
    end
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
